/* sv/delta_index_chunk_search_macros.svh */
// Assertion macros used by the delta index chunk search top level.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef DELTA_INDEX_CHUNK_SEARCH_MACROS_SVH
`define DELTA_INDEX_CHUNK_SEARCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define DICS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DICS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dics_pkg.sv */
// Package for the delta index chunk search: beat types, codes, FSM states.
// No dependencies; used by the top level and the bench.
`default_nettype none

package dics_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int HEADER_BYTES = 8;
  localparam int HDR_W        = $clog2(HEADER_BYTES + 1);
  localparam int ENTRY_W      = 24;
  localparam int OFF_W        = 23;

  // mode codes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FIND = 2'd1;
  localparam logic [1:0] MODE_PREV = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // body phase codes: bytes of the current element seen
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  chunk_byte;
    logic        chunk_last;
    logic [63:0] query_block;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [63:0] hit_block;
    logic        rec_start;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_FETCH,
    S_EMIT
  } state_t;

  function automatic logic [1:0] chunk_status(input logic [HDR_W-1:0] hdr_cnt,
                                              input logic [1:0]       phase,
                                              input logic             ovf);
    logic [1:0] st;
    if (hdr_cnt < HDR_W'(HEADER_BYTES)) st = ST_SHORT;
    else if (phase != PH_NONE)          st = ST_BAD_LEN;
    else if (ovf)                       st = ST_OVERFLOW;
    else                                st = ST_OK;
    return st;
  endfunction

endpackage

`default_nettype wire

/* sv/dics_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dics_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/delta_index_chunk_search.sv */
// Top level of the delta index chunk search: chunk loader, binary search FSM.
// Depends on dics_pkg, dics_ram and delta_index_chunk_search_macros.svh.
//
//  channel | dir | handshake            | beat
//  --------+-----+----------------------+------------------
//  in_     | in  | in_valid / in_ready  | dics_pkg::in_t
//  out_    | out | out_valid / out_ready| dics_pkg::out_t
//
// One item at a time. A load byte that is not final is accepted in S_IDLE; a final
// byte or a query on a bad chunk is accepted, then emitted from S_EMIT. A search
// makes one element-store read per probe, compare folded into the next address.
// Reset is synchronous, active low, and clears control state only; the store is
// never cleared. in_ready is low while a search runs or a result waits for a free
// output register.
`default_nettype none
`include "delta_index_chunk_search_macros.svh"

module delta_index_chunk_search (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dics_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dics_pkg::out_t      out_data
);

  import dics_pkg::*;

  state_t             state_r, state_nxt;

  // chunk state
  logic [63:0]        base_r, base_nxt;
  logic [HDR_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [15:0]        part_r, part_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [CNT_W-1:0]   elem_cnt_r, elem_cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               closed_r, closed_nxt;

  // search state
  logic [63:0]        q_r, q_nxt;
  logic               prev_r, prev_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  out_t               res_r, res_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  // store port
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // control flags to the FSM
  logic               accept;
  logic               go_emit;
  logic               go_srch;
  logic               srch_more;
  logic               srch_hit;
  logic               out_free;

  // datapath temporaries
  logic [63:0]        eff_base;
  logic [HDR_W-1:0]   eff_hdr;
  logic [15:0]        eff_part;
  logic [1:0]         eff_phase;
  logic [CNT_W-1:0]   eff_cnt;
  logic               eff_ovf;
  logic [1:0]         cur_status;
  logic [63:0]        probe_blk;
  logic               probe_lt;
  logic [CNT_W-1:0]   half;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   lo_step;
  logic [CNT_W-1:0]   n_step;
  logic [CNT_W-1:0]   target;

  dics_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    unique case (state_r) inside
      S_IDLE:  in_ready = 1'b1;
      S_SRCH,
      S_FETCH,
      S_EMIT:  in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (go_srch)      state_nxt = S_SRCH;
        else if (go_emit) state_nxt = S_EMIT;
      end
      S_SRCH: begin
        if (!srch_more) state_nxt = srch_hit ? S_FETCH : S_EMIT;
      end
      S_FETCH: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    base_nxt     = base_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    part_nxt     = part_r;
    phase_nxt    = phase_r;
    elem_cnt_nxt = elem_cnt_r;
    ovf_nxt      = ovf_r;
    closed_nxt   = closed_r;
    q_nxt        = q_r;
    prev_nxt     = prev_r;
    lo_nxt       = lo_r;
    n_nxt        = n_r;
    res_nxt      = res_r;
    wr_en        = 1'b0;
    wr_addr      = elem_cnt_r[IDX_W-1:0];
    wr_data      = {part_r, in_data.chunk_byte};
    rd_addr      = '0;
    go_emit      = 1'b0;
    go_srch      = 1'b0;
    srch_more    = 1'b0;
    srch_hit     = 1'b0;

    // a byte on a closed chunk starts a fresh one
    eff_base  = closed_r ? 64'd0 : base_r;
    eff_hdr   = closed_r ? '0 : hdr_cnt_r;
    eff_part  = closed_r ? 16'd0 : part_r;
    eff_phase = closed_r ? PH_NONE : phase_r;
    eff_cnt   = closed_r ? '0 : elem_cnt_r;
    eff_ovf   = closed_r ? 1'b0 : ovf_r;

    cur_status = chunk_status(hdr_cnt_r, phase_r, ovf_r);

    probe_blk = base_r + {{(64-OFF_W){1'b0}}, rd_data[OFF_W-1:0]};
    probe_lt  = probe_blk < q_r;
    half      = n_r >> 1;
    mid       = lo_r + half;
    lo_step   = probe_lt ? mid + CNT_W'(1) : lo_r;
    n_step    = probe_lt ? n_r - half - CNT_W'(1) : half;
    target    = prev_r ? lo_step - CNT_W'(1) : lo_step;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.mode) inside
            MODE_LOAD: begin
              base_nxt     = eff_base;
              hdr_cnt_nxt  = eff_hdr;
              part_nxt     = eff_part;
              phase_nxt    = eff_phase;
              elem_cnt_nxt = eff_cnt;
              ovf_nxt      = eff_ovf;
              wr_addr      = eff_cnt[IDX_W-1:0];
              wr_data      = {eff_part, in_data.chunk_byte};
              if (eff_hdr < HDR_W'(HEADER_BYTES)) begin
                base_nxt    = {eff_base[55:0], in_data.chunk_byte};
                hdr_cnt_nxt = eff_hdr + HDR_W'(1);
              end else begin
                case (eff_phase)
                  PH_NONE: begin
                    part_nxt  = {8'd0, in_data.chunk_byte};
                    phase_nxt = PH_ONE;
                  end
                  PH_ONE: begin
                    part_nxt  = {eff_part[7:0], in_data.chunk_byte};
                    phase_nxt = PH_TWO;
                  end
                  default: begin
                    if (eff_cnt < CNT_W'(MAX_ELEMENTS)) begin
                      wr_en        = 1'b1;
                      elem_cnt_nxt = eff_cnt + CNT_W'(1);
                    end else begin
                      ovf_nxt = 1'b1;
                    end
                    phase_nxt = PH_NONE;
                  end
                endcase
              end
              closed_nxt = in_data.chunk_last;
              if (in_data.chunk_last) begin
                res_nxt        = '0;
                res_nxt.status = chunk_status(hdr_cnt_nxt, phase_nxt, ovf_nxt);
                go_emit        = 1'b1;
              end
            end
            MODE_FIND, MODE_PREV: begin
              res_nxt  = '0;
              q_nxt    = in_data.query_block;
              prev_nxt = (in_data.mode == MODE_PREV);
              lo_nxt   = '0;
              n_nxt    = elem_cnt_r;
              rd_addr  = elem_cnt_r[CNT_W-1:1];
              if (cur_status != ST_OK) begin
                res_nxt.status = cur_status;
                go_emit        = 1'b1;
              end else if (elem_cnt_r == '0) begin
                go_emit = 1'b1;
              end else begin
                go_srch = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        // rd_data holds the entry at mid; fold the compare into the next probe
        lo_nxt = lo_step;
        n_nxt  = n_step;
        if (n_step != '0) begin
          srch_more = 1'b1;
          rd_addr   = IDX_W'(lo_step + (n_step >> 1));
        end else begin
          srch_hit = prev_r ? (lo_step != '0) : (lo_step < elem_cnt_r);
          rd_addr  = target[IDX_W-1:0];
          res_nxt  = '0;
        end
      end
      S_FETCH: begin
        res_nxt.status    = ST_OK;
        res_nxt.found     = 1'b1;
        res_nxt.hit_block = probe_blk;
        res_nxt.rec_start = rd_data[ENTRY_W-1];
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (state_r == S_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      hdr_cnt_r   <= '0;
      part_r      <= '0;
      phase_r     <= PH_NONE;
      elem_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      closed_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      part_r      <= part_nxt;
      phase_r     <= phase_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      ovf_r       <= ovf_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    prev_r     <= prev_nxt;
    lo_r       <= lo_nxt;
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `DICS_ASSERT_IMP(a_cnt_cap, 1'b1, elem_cnt_r <= CNT_W'(MAX_ELEMENTS), "count over capacity")
  `DICS_ASSERT_IMP(a_srch_live, state_r == S_SRCH, n_r != '0, "search probing an empty range")
  `DICS_ASSERT_IMP(a_srch_range, state_r == S_SRCH, ((lo_r + n_r) <= elem_cnt_r), "range overrun")
  `DICS_ASSERT_NXT(a_emit, state_r == S_EMIT && out_free, out_valid_r && state_r == S_IDLE, "lost")
  `DICS_ASSERT_IMP(a_no_store_wr, state_r != S_IDLE, !wr_en, "store written during a search")

endmodule

`default_nettype wire

/* bench/delta_index_chunk_search_tb.sv */
// Self-checking bench for delta_index_chunk_search: chunk loads and lower-bound queries.
// Depends on dics_pkg and the delta_index_chunk_search RTL; has its own shadow predictor.
`timescale 1ns / 100ps

module delta_index_chunk_search_tb;
  import dics_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BEATS = 420;
  localparam int OFF_MAX = 'h7FFFFF;

  typedef struct {
    in_t beat;
    bit typed;
    logic [1:0] typed_st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // shadow copy of the chunk state
  logic [63:0] idx_base = '0;
  logic [23:0] idx_store [MAX_ELEMENTS];
  int hdr_seen = 0;
  logic [15:0] part_elem = '0;
  int elem_cnt = 0;
  bit ovf_seen = 1'b0;
  bit chunk_done = 1'b1;
  logic [1:0] body_ph = PH_NONE;

  out_t pending [$];
  row_t dir_rows [$];
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int mismatches = 0;
  int n_beats = 0;
  int n_checked = 0;
  int n_closed = 0;
  int quiet = 0;

  delta_index_chunk_search uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] load_status();
    if (hdr_seen < HEADER_BYTES) return ST_SHORT;
    if (body_ph != PH_NONE) return ST_BAD_LEN;
    if (ovf_seen) return ST_OVERFLOW;
    return ST_OK;
  endfunction

  function automatic logic [63:0] blk_at(int i);
    return idx_base + 64'(idx_store[i][22:0]);
  endfunction

  // advances the shadow state by one beat; returns 1 when the beat yields a result
  function automatic bit predict_beat(input in_t b, output out_t r);
    int lo;
    int n;
    int half;
    bit hit;
    r = '0;
    if (b.mode == MODE_NONE) return 1'b0;
    if (b.mode == MODE_LOAD) begin
      if (chunk_done) begin
        idx_base = '0;
        hdr_seen = 0;
        part_elem = '0;
        elem_cnt = 0;
        ovf_seen = 1'b0;
        body_ph = PH_NONE;
        chunk_done = 1'b0;
      end
      if (hdr_seen < HEADER_BYTES) begin
        idx_base = {idx_base[55:0], b.chunk_byte};
        hdr_seen++;
      end else if (body_ph == PH_NONE) begin
        part_elem = {8'd0, b.chunk_byte};
        body_ph = PH_ONE;
      end else if (body_ph == PH_ONE) begin
        part_elem = {part_elem[7:0], b.chunk_byte};
        body_ph = PH_TWO;
      end else begin
        if (elem_cnt < MAX_ELEMENTS) begin
          idx_store[elem_cnt] = {part_elem, b.chunk_byte};
          elem_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
        body_ph = PH_NONE;
      end
      if (!b.chunk_last) return 1'b0;
      chunk_done = 1'b1;
      r.status = load_status();
      n_closed++;
      return 1'b1;
    end
    r.status = load_status();
    if (r.status != ST_OK) return 1'b1;
    lo = 0;
    n = elem_cnt;
    while (n > 0) begin
      half = n / 2;
      if (blk_at(lo + half) < b.query_block) begin
        lo = lo + half + 1;
        n -= half + 1;
      end else begin
        n = half;
      end
    end
    if (b.mode == MODE_FIND) begin
      hit = lo < elem_cnt;
    end else begin
      hit = lo > 0;
      if (hit) lo--;
    end
    if (hit) begin
      r.found = 1'b1;
      r.hit_block = blk_at(lo);
      r.rec_start = idx_store[lo][23];
    end
    return 1'b1;
  endfunction

  function automatic row_t drow(logic [1:0] m, logic [7:0] b, logic l, logic [63:0] q,
                                bit typed, logic [1:0] st);
    row_t r;
    r.beat = '{mode: m, chunk_byte: b, chunk_last: l, query_block: q};
    r.typed = typed;
    r.typed_st = st;
    return r;
  endfunction

  // query values: extremes, random, and neighbors of stored blocks
  function automatic logic [63:0] pick_query();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      3: return idx_base + 64'($urandom_range(0, OFF_MAX));
      default: begin
        if (elem_cnt == 0) return {$urandom, $urandom};
        return blk_at($urandom_range(0, elem_cnt - 1)) + 64'($urandom_range(0, 2)) - 64'd1;
      end
    endcase
  endfunction

  task automatic put_beat(input in_t beat, input bit typed, input logic [1:0] typed_st);
    int gap;
    bit has_res;
    out_t res;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    has_res = predict_beat(beat, res);
    if (has_res) begin
      if (typed) res = '{status: typed_st, found: 1'b0, hit_block: '0, rec_start: 1'b0};
      pending.push_back(res);
    end
    if (beat.mode != MODE_NONE) n_beats++;
  endtask

  task automatic put_load(input logic [7:0] b, input logic l);
    put_beat('{mode: MODE_LOAD, chunk_byte: b, chunk_last: l,
               query_block: {$urandom, $urandom}}, 1'b0, ST_OK);
  endtask

  task automatic put_query();
    put_beat('{mode: ($urandom_range(0, 1) ? MODE_FIND : MODE_PREV),
               chunk_byte: 8'($urandom), chunk_last: 1'($urandom),
               query_block: pick_query()}, 1'b0, ST_OK);
  endtask

  // hold the input side until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic push_elem(inout logic [7:0] bytes [$], input logic [23:0] e);
    bytes.push_back(e[23:16]);
    bytes.push_back(e[15:8]);
    bytes.push_back(e[7:0]);
  endtask

  task automatic gen_chunk();
    int kind;
    int nel;
    int step_max;
    int off;
    int keep;
    int i;
    logic [63:0] base;
    logic [7:0] bytes [$];
    kind = $urandom_range(0, 9);
    tx_idle = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 'hFFFFFF));
      default: base = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 2))
      0: step_max = 2;
      1: step_max = 1000;
      default: step_max = 200000;
    endcase
    nel = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    for (i = 7; i >= 0; i--) bytes.push_back(base[8*i +: 8]);
    off = $urandom_range(0, 2000);
    for (i = 0; i < nel; i++) begin
      if (kind == 2) begin
        off = $urandom_range(0, OFF_MAX);
      end else begin
        off += $urandom_range(0, step_max);
        if (off > OFF_MAX) off = OFF_MAX;
      end
      push_elem(bytes, {1'($urandom), 23'(off)});
    end
    if (kind == 0) begin
      keep = $urandom_range(1, 7);
      while (bytes.size() > keep) void'(bytes.pop_back());
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 2)) bytes.push_back(8'($urandom));
    end
    for (i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 15) == 0) put_query();
      if ($urandom_range(0, 29) == 0)
        put_beat('{mode: MODE_NONE, chunk_byte: 8'($urandom), chunk_last: 1'($urandom),
                   query_block: {$urandom, $urandom}}, 1'b0, ST_OK);
      put_load(bytes[i], i == bytes.size() - 1);
    end
    repeat ($urandom_range(1, 8)) put_query();
  endtask

  task automatic flag_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall before each beat while rx_idle is set
  initial begin
    int gap;
    int rx_beats;
    rx_beats = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      rx_beats++;
      if (rx_beats % 40 == 0) rx_idle = $urandom_range(0, 2) != 0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending.pop_front();
        flag_field("status", 64'(want.status), 64'(out_data.status));
        flag_field("found", 64'(want.found), 64'(out_data.found));
        flag_field("hit_block", want.hit_block, out_data.hit_block);
        flag_field("rec_start", 64'(want.rec_start), 64'(out_data.rec_start));
        n_checked++;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending.size());
      $display("delta_index_chunk_search_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int i;
    int stop_at;
    // empty store, short and bad-length chunks, wrap of the block sum, unordered pair
    dir_rows.push_back(drow(MODE_FIND, 8'h00, 1'b0, 64'd0, 1'b1, ST_SHORT));
    dir_rows.push_back(drow(MODE_PREV, 8'hFF, 1'b1, '1, 1'b1, ST_SHORT));
    dir_rows.push_back(drow(MODE_NONE, 8'hFF, 1'b1, '1, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'h5A, 1'b1, 64'd0, 1'b1, ST_SHORT));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hF0, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_FIND, 8'h00, 1'b0, 64'd0, 1'b1, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'h80, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'h00, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'h05, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'h7F, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'hFF, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_FIND, 8'h00, 1'b0, 64'd0, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_PREV, 8'h00, 1'b0, '1, 1'b0, ST_OK));
    dir_rows.push_back(drow(MODE_LOAD, 8'h00, 1'b1, 64'd0, 1'b1, ST_BAD_LEN));
    dir_rows.push_back(drow(MODE_FIND, 8'h00, 1'b0, 64'd0, 1'b1, ST_BAD_LEN));
    dir_rows.push_back(drow(MODE_PREV, 8'h00, 1'b0, '1, 1'b1, ST_BAD_LEN));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < dir_rows.size(); i++)
      put_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].typed_st);

    drain();

    stop_at = n_beats + RANDOM_BEATS;
    while (n_beats < stop_at) begin
      if ($urandom_range(0, 7) == 0) drain();
      gen_chunk();
    end

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d input beats, %0d results checked, %0d chunks closed",
             n_beats, n_checked, n_closed);
    $display("chunks mixed short, odd-length, unordered and wrapping bodies; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("delta_index_chunk_search_tb OK");
    end else begin
      $display("delta_index_chunk_search_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/dics_pkg.sv
sv/dics_ram.sv
sv/delta_index_chunk_search.sv
bench/delta_index_chunk_search_tb.sv
